// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define IMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define IMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/imt_pkg.sv =====
// types, codes and sizes shared by the interval mark table
package imt_pkg;

  localparam int ADDR_BITS = 16;
  localparam int SLOT_W = 6;
  localparam int COUNT_W = 7;
  localparam int DEF_TABLE_DEPTH = 64;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } imt_status_t;

  typedef enum logic {
    CMD_MARK = 1'b0,
    CMD_READ = 1'b1
  } imt_cmd_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } imt_state_t;

  typedef struct packed {
    imt_cmd_t              cmd;
    logic [ADDR_BITS-1:0]  range_start;
    logic [ADDR_BITS-1:0]  range_end;
    logic [SLOT_W-1:0]     entry_index;
  } imt_in_t;

  typedef struct packed {
    imt_status_t           status;
    logic [ADDR_BITS-1:0]  entry_start;
    logic [ADDR_BITS-1:0]  entry_end;
    logic [SLOT_W-1:0]     entry_slot;
    logic [COUNT_W-1:0]    entry_count;
  } imt_out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS-1:0] hi;
  } imt_entry_t;

  typedef struct packed {
    logic capture;
    logic bad_range;
    logic apply;
    logic append;
  } imt_ctl_t;

endpackage

// ===== src/imt_cell.sv =====
// one table slot: holds an interval, compares a request against it, merges or loads it
module imt_cell import imt_pkg::*; #(
  parameter int CELL_ID = 0,
  parameter int CW = 7,
  parameter int IW = 6
) (
  input  logic          clk,
  input  imt_ctl_t      ctl,
  input  imt_in_t       in_req,
  input  imt_in_t       cur_req,
  input  logic [CW-1:0] count,
  input  logic          prev_hit,
  output logic          next_hit,
  output imt_entry_t    sel_entry,
  output logic [IW-1:0] sel_slot
);

  logic       match_r;
  logic       match_nxt;
  imt_entry_t entry_r;
  imt_entry_t entry_nxt;
  imt_entry_t merged;
  logic       in_use;
  logic       overlap;
  logic       first;

  assign in_use  = 32'(CELL_ID) < 32'(count);
  assign overlap = !((entry_r.lo > in_req.range_end) || (entry_r.hi < in_req.range_start));

  always_comb begin
    if (in_req.cmd == CMD_READ) begin
      match_nxt = in_use && (32'(in_req.entry_index) == 32'(CELL_ID));
    end else begin
      match_nxt = in_use && overlap && !ctl.bad_range;
    end
  end

  assign next_hit = prev_hit | match_r;
  assign first    = match_r & ~prev_hit;

  assign merged.lo = (cur_req.range_start < entry_r.lo) ? cur_req.range_start : entry_r.lo;
  assign merged.hi = (cur_req.range_end > entry_r.hi) ? cur_req.range_end : entry_r.hi;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.apply && first && (cur_req.cmd == CMD_MARK)) begin
      entry_nxt = merged;
    end else if (ctl.append && (32'(count) == 32'(CELL_ID))) begin
      entry_nxt.lo = cur_req.range_start;
      entry_nxt.hi = cur_req.range_end;
    end
  end

  always_comb begin
    sel_entry = '0;
    sel_slot  = '0;
    if (first) begin
      sel_entry = (cur_req.cmd == CMD_READ) ? entry_r : merged;
      sel_slot  = IW'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.capture) begin
      match_r <= match_nxt;
    end
  end

endmodule

// ===== src/interval_mark_table.sv =====
// top level of the interval mark table: a row of slot cells and the request sequencer
//
// A request is taken when start is high and busy is low. Every cell compares the
// request against its interval in the accept cycle; in the following cycle (busy
// high) the first hit is found along the cell chain and merged, or the interval is
// appended, or the slot is read. The result appears on out_res for exactly one cycle
// with out_valid high, in the cycle after the update cycle, and busy is already low
// then, so a request passes through the compare cycle and the update cycle. There is
// one result per request and the receiver cannot stall it.
module interval_mark_table import imt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  imt_in_t  in_req,
  output logic     out_valid,
  output imt_out_t out_res
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  imt_state_t    state_r;
  imt_state_t    state_nxt;
  imt_in_t       req_r;
  logic          bad_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  imt_out_t      out_r;
  imt_out_t      out_nxt;
  logic          out_valid_r;
  logic          accept;
  logic          any_hit;
  logic          full;
  imt_ctl_t      ctl;
  imt_entry_t    hit_entry;
  logic [IW-1:0] hit_slot;

  logic       hit_chain [TABLE_DEPTH+1];
  imt_entry_t cell_entry [TABLE_DEPTH];
  logic [IW-1:0] cell_slot [TABLE_DEPTH];

  assign accept  = start && (state_r == ST_IDLE);
  assign any_hit = hit_chain[TABLE_DEPTH];
  assign full    = count_r == CW'(TABLE_DEPTH);
  assign hit_chain[0] = 1'b0;

  assign ctl.capture   = accept;
  assign ctl.bad_range = in_req.range_end < in_req.range_start;
  assign ctl.apply     = state_r == ST_APPLY;
  assign ctl.append    = (state_r == ST_APPLY) && (req_r.cmd == CMD_MARK) && !bad_r
                         && !any_hit && !full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    imt_cell #(
      .CELL_ID (i),
      .CW      (CW),
      .IW      (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_req    (in_req),
      .cur_req   (req_r),
      .count     (count_r),
      .prev_hit  (hit_chain[i]),
      .next_hit  (hit_chain[i+1]),
      .sel_entry (cell_entry[i]),
      .sel_slot  (cell_slot[i])
    );
  end

  always_comb begin
    hit_entry = '0;
    hit_slot  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_entry = hit_entry | cell_entry[i];
      hit_slot  = hit_slot | cell_slot[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    out_nxt   = '0;
    if (req_r.cmd == CMD_READ) begin
      if (any_hit) begin
        out_nxt.status      = STAT_OK;
        out_nxt.entry_start = hit_entry.lo;
        out_nxt.entry_end   = hit_entry.hi;
        out_nxt.entry_slot  = SLOT_W'(hit_slot);
      end else begin
        out_nxt.status = STAT_BAD_INDEX;
      end
    end else if (bad_r) begin
      out_nxt.status = STAT_BAD_RANGE;
    end else if (any_hit) begin
      out_nxt.status      = STAT_OK;
      out_nxt.entry_start = hit_entry.lo;
      out_nxt.entry_end   = hit_entry.hi;
      out_nxt.entry_slot  = SLOT_W'(hit_slot);
    end else if (full) begin
      out_nxt.status = STAT_FULL;
    end else begin
      out_nxt.status      = STAT_OK;
      out_nxt.entry_start = req_r.range_start;
      out_nxt.entry_end   = req_r.range_end;
      out_nxt.entry_slot  = SLOT_W'(count_r);
      count_nxt           = count_r + CW'(1);
    end
    out_nxt.entry_count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == ST_APPLY;
      if (state_r == ST_APPLY) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
      bad_r <= ctl.bad_range;
    end
    if (state_r == ST_APPLY) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = state_r == ST_APPLY;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== src/imt_checker.sv =====
// port-level checks for the interval mark table, bound to the top level
`include "assert_macros.svh"

module imt_checker import imt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input imt_out_t out_res
);

  // a taken request makes the block busy in the next cycle
  `IMT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // update cycle is followed by the result strobe with the block free again
  `IMT_ASSERT_NEXT(a_busy_result, clk, rst_n, busy, !busy && out_valid)

  // a reported entry is never an inverted interval
  `IMT_ASSERT_NOW(a_ok_ordered, clk, rst_n, out_valid && (out_res.status == STAT_OK),
    out_res.entry_start <= out_res.entry_end)

  // error results carry no entry
  `IMT_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_res.status != STAT_OK),
    (out_res.entry_start == '0) && (out_res.entry_end == '0) && (out_res.entry_slot == '0))

endmodule

bind interval_mark_table imt_checker u_imt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);
